/* rtl/bcu_pkg.sv */
// ----------------------------------------------------------------------------
// bcu_pkg
// Shared types, constants and saturating arithmetic for the undistort block.
// ----------------------------------------------------------------------------
package bcu_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int CNT_W        = $clog2(CORDIC_STEPS);
	localparam int ATAN_N       = 30;
	localparam int ATAN_IW      = $clog2(ATAN_N);
	localparam int NSTG         = 21;
	localparam int ADDR_W       = 6;

	localparam logic signed [32:0] COR_GAIN    = 33'sd652032874;
	localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
	localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
	localparam logic signed [31:0] Q30_ONE     = 32'sd1073741824;
	localparam logic signed [63:0] Q56_ONE     = 64'sh0100_0000_0000_0000;
	localparam logic signed [63:0] S64_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN     = 64'sh8000_0000_0000_0000;
	localparam logic signed [31:0] S32_MAX     = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN     = 32'sh8000_0000;

	localparam logic [29:0] ATAN_TBL [ATAN_N] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
		30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
		30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
		30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
		30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
		30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002
	};

	// coefficient slots
	localparam int COEF_K1 = 0;
	localparam int COEF_K2 = 1;
	localparam int COEF_K3 = 2;
	localparam int COEF_P1 = 3;
	localparam int COEF_P2 = 4;
	localparam int COEF_N  = 5;

	typedef enum logic [2:0] {
		REG_PRINCIPAL_X    = 3'd0,
		REG_PRINCIPAL_Y    = 3'd1,
		REG_RADIAL_K1      = 3'd2,
		REG_RADIAL_K2      = 3'd3,
		REG_RADIAL_K3      = 3'd4,
		REG_DECENTER_P1    = 3'd5,
		REG_DECENTER_P2    = 3'd6,
		REG_DECENTER_ANGLE = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		COR_IDLE,
		COR_RUN,
		COR_FIN,
		COR_MAG
	} cor_state_t;

	typedef struct packed {
		logic               clamp;
		logic signed [63:0] val;
	} sat64_t;

	typedef struct packed {
		logic               clamp;
		logic signed [31:0] val;
	} sat32_t;

	// side band that travels with every word down the pipeline
	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic [31:0]        cxm;
		logic [31:0]        cym;
		logic               cxn;
		logic               cyn;
		logic [63:0]        r2;
		logic signed [63:0] shx;
		logic signed [63:0] shy;
		logic               clamp;
	} side_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] a);
		mag64 = a[63] ? 64'(-a) : 64'(a);
	endfunction

	// truncate magnitude product toward zero, apply sign, clamp to 64 bits
	function automatic sat64_t sat_shift(input logic [127:0] prod, input logic neg,
			input int sh);
		logic [127:0] t;
		logic         over;
		logic [63:0]  q;
		sat64_t       r;
		t    = prod >> sh;
		over = |t[127:64];
		q    = t[63:0];
		if (!neg) begin
			r.clamp = over | q[63];
			r.val   = r.clamp ? S64_MAX : $signed(q);
		end else begin
			r.clamp = over | (q > 64'h8000_0000_0000_0000);
			r.val   = r.clamp ? S64_MIN : $signed(-q);
		end
		return r;
	endfunction

	function automatic sat64_t sadd64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		sat64_t             r;
		s       = 65'(a) + 65'(b);
		r.clamp = s[64] != s[63];
		r.val   = r.clamp ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
		return r;
	endfunction

	function automatic sat64_t ssub64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		sat64_t             r;
		s       = 65'(a) - 65'(b);
		r.clamp = s[64] != s[63];
		r.val   = r.clamp ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
		return r;
	endfunction

	function automatic sat32_t sat32(input logic signed [63:0] v);
		sat32_t r;
		r.clamp = !((&v[63:31]) | ~(|v[63:31]));
		r.val   = r.clamp ? (v[63] ? S32_MIN : S32_MAX) : v[31:0];
		return r;
	endfunction

endpackage

/* rtl/bcu_mul.sv */
// ----------------------------------------------------------------------------
// bcu_mul
// Two-stage 64x64 unsigned magnitude multiplier: 32x32 partials, then sum.
// ----------------------------------------------------------------------------
module bcu_mul (
	input  logic         clk,
	input  logic         en,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	input  logic         neg,
	output logic [127:0] prod,
	output logic         prod_neg
);

	logic [63:0]  ll_s1, hl_s1, lh_s1, hh_s1;
	logic         neg_s1;
	logic [127:0] prod_s2;
	logic         neg_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1  <= a[31:0]  * b[31:0];
			hl_s1  <= a[63:32] * b[31:0];
			lh_s1  <= a[31:0]  * b[63:32];
			hh_s1  <= a[63:32] * b[63:32];
			neg_s1 <= neg;
			prod_s2 <= {64'd0, ll_s1} + {32'd0, hl_s1, 32'd0}
				+ {32'd0, lh_s1, 32'd0} + {hh_s1, 64'd0};
			neg_s2  <= neg_s1;
		end
	end

	assign prod     = prod_s2;
	assign prod_neg = neg_s2;

endmodule

/* rtl/brown_conrady_undistort_top.sv */
// ----------------------------------------------------------------------------
// brown_conrady_undistort_top
// Brown-Conrady lens undistortion of Q16.16 points, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | signals                               | dir | handshake
//  ---------+---------------------------------------+-----+------------------
//  point    | pixel_x/y, camera_offset_x/y          | in  | point_valid/stall
//  result   | undistorted_x/y, saturated            | out | result_valid/stall
//  config   | psel penable pwrite paddr pwdata ...  | in  | APB, pready tied 1
//
//  One word per clock unless point_stall is high; a word passes 21 pipeline
//  stages plus the output register. The 64x64 products are the pacing units:
//  each is split into 32x32 partials, a sum stage and a shift/saturate stage.
//  A write to the angle register starts a CORDIC_STEPS-iteration CORDIC;
//  point_stall is held high while it runs.
//  Reset clears valid bits and config registers, sets cos to one, sin to zero.
//  The pipeline only freezes when the last stage holds a word and the
//  output register is full and stalled; bubbles squeeze out otherwise.
// ----------------------------------------------------------------------------
module brown_conrady_undistort_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// point channel
	input  logic                        point_valid,
	output logic                        point_stall,
	input  logic signed [31:0]          pixel_x,
	input  logic signed [31:0]          pixel_y,
	input  logic signed [31:0]          camera_offset_x,
	input  logic signed [31:0]          camera_offset_y,
	// result channel
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic signed [31:0]          undistorted_x,
	output logic signed [31:0]          undistorted_y,
	output logic                        saturated,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bcu_pkg::ADDR_W-1:0]  paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready
);

	import bcu_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic               cfg_wr;
	reg_idx_t           cfg_idx;
	logic signed [31:0] prx_q, pry_q, angle_q;
	logic signed [63:0] coef_q     [COEF_N];
	logic [63:0]        coef_mag_q [COEF_N];
	logic               coef_neg_q [COEF_N];
	logic               angle_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign cfg_idx  = reg_idx_t'(paddr[5:3]);
	assign angle_wr = cfg_wr && (cfg_idx == REG_DECENTER_ANGLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prx_q   <= '0;
			pry_q   <= '0;
			angle_q <= '0;
			for (int i = 0; i < COEF_N; i++) begin
				coef_q[i]     <= '0;
				coef_mag_q[i] <= '0;
				coef_neg_q[i] <= 1'b0;
			end
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_PRINCIPAL_X: prx_q <= pwdata[31:0];
				REG_PRINCIPAL_Y: pry_q <= pwdata[31:0];
				REG_RADIAL_K1: begin
					coef_q[COEF_K1]     <= pwdata;
					coef_mag_q[COEF_K1] <= mag64(pwdata);
					coef_neg_q[COEF_K1] <= pwdata[63];
				end
				REG_RADIAL_K2: begin
					coef_q[COEF_K2]     <= pwdata;
					coef_mag_q[COEF_K2] <= mag64(pwdata);
					coef_neg_q[COEF_K2] <= pwdata[63];
				end
				REG_RADIAL_K3: begin
					coef_q[COEF_K3]     <= pwdata;
					coef_mag_q[COEF_K3] <= mag64(pwdata);
					coef_neg_q[COEF_K3] <= pwdata[63];
				end
				REG_DECENTER_P1: begin
					coef_q[COEF_P1]     <= pwdata;
					coef_mag_q[COEF_P1] <= mag64(pwdata);
					coef_neg_q[COEF_P1] <= pwdata[63];
				end
				REG_DECENTER_P2: begin
					coef_q[COEF_P2]     <= pwdata;
					coef_mag_q[COEF_P2] <= mag64(pwdata);
					coef_neg_q[COEF_P2] <= pwdata[63];
				end
				REG_DECENTER_ANGLE: angle_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_PRINCIPAL_X:    prdata = 64'(prx_q);
			REG_PRINCIPAL_Y:    prdata = 64'(pry_q);
			REG_RADIAL_K1:      prdata = coef_q[COEF_K1];
			REG_RADIAL_K2:      prdata = coef_q[COEF_K2];
			REG_RADIAL_K3:      prdata = coef_q[COEF_K3];
			REG_DECENTER_P1:    prdata = coef_q[COEF_P1];
			REG_DECENTER_P2:    prdata = coef_q[COEF_P2];
			REG_DECENTER_ANGLE: prdata = 64'(angle_q);
			default:            prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sine/cosine CORDIC, runs after an angle write
	// ------------------------------------------------------------------
	cor_state_t         cor_state_q, cor_state_d;
	logic [CNT_W-1:0]   cor_cnt_q;
	logic signed [32:0] cor_x_q, cor_y_q;
	logic signed [33:0] cor_z_q, z_init, z_fold;
	logic               flip_q, flip_init;
	logic signed [31:0] sin_q, cos_q;
	logic [31:0]        sin_mag_q, cos_mag_q;
	logic               sin_neg_q, cos_neg_q;
	logic signed [33:0] atan_step;
	logic               cor_busy;

	assign cor_busy  = cor_state_q != COR_IDLE;
	assign atan_step = $signed({4'd0, ATAN_TBL[ATAN_IW'(cor_cnt_q)]});
	assign z_init    = {pwdata[31], pwdata[31:0], 1'b0};

	// fold by pi into the CORDIC's convergence range
	always_comb begin
		z_fold    = z_init;
		flip_init = 1'b0;
		if (z_init > Q30_HALF_PI) begin
			z_fold    = z_init - Q30_PI;
			flip_init = 1'b1;
		end else if (z_init < -Q30_HALF_PI) begin
			z_fold    = z_init + Q30_PI;
			flip_init = 1'b1;
		end
	end

	always_comb begin
		cor_state_d = cor_state_q;
		case (cor_state_q)
			COR_IDLE: if (angle_wr) cor_state_d = COR_RUN;
			COR_RUN:  if (cor_cnt_q == CNT_W'(CORDIC_STEPS - 1)) cor_state_d = COR_FIN;
			COR_FIN:  cor_state_d = COR_MAG;
			COR_MAG:  cor_state_d = COR_IDLE;
			default:  cor_state_d = COR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cor_state_q <= COR_IDLE;
			cor_cnt_q   <= '0;
			cor_x_q     <= '0;
			cor_y_q     <= '0;
			cor_z_q     <= '0;
			flip_q      <= 1'b0;
			sin_q       <= '0;
			cos_q       <= Q30_ONE;
			sin_mag_q   <= '0;
			cos_mag_q   <= 32'(Q30_ONE);
			sin_neg_q   <= 1'b0;
			cos_neg_q   <= 1'b0;
		end else begin
			cor_state_q <= cor_state_d;
			case (cor_state_q)
				COR_IDLE: begin
					if (angle_wr) begin
						cor_cnt_q <= '0;
						cor_x_q   <= COR_GAIN;
						cor_y_q   <= '0;
						cor_z_q   <= z_fold;
						flip_q    <= flip_init;
					end
				end
				COR_RUN: begin
					cor_cnt_q <= cor_cnt_q + 1'b1;
					if (!cor_z_q[33]) begin
						cor_x_q <= cor_x_q - (cor_y_q >>> cor_cnt_q);
						cor_y_q <= cor_y_q + (cor_x_q >>> cor_cnt_q);
						cor_z_q <= cor_z_q - atan_step;
					end else begin
						cor_x_q <= cor_x_q + (cor_y_q >>> cor_cnt_q);
						cor_y_q <= cor_y_q - (cor_x_q >>> cor_cnt_q);
						cor_z_q <= cor_z_q + atan_step;
					end
				end
				COR_FIN: begin
					cos_q <= flip_q ? 32'(-cor_x_q) : cor_x_q[31:0];
					sin_q <= flip_q ? 32'(-cor_y_q) : cor_y_q[31:0];
				end
				COR_MAG: begin
					cos_mag_q <= cos_q[31] ? 32'(-cos_q) : 32'(cos_q);
					sin_mag_q <= sin_q[31] ? 32'(-sin_q) : 32'(sin_q);
					cos_neg_q <= cos_q[31];
					sin_neg_q <= sin_q[31];
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control
	// ------------------------------------------------------------------
	logic [NSTG:1] vld_q;
	logic          adv, take;
	logic          res_valid_q;

	assign adv         = !(vld_q[NSTG] && res_valid_q && result_stall);
	assign point_stall = !adv || cor_busy;
	assign take        = point_valid && !point_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-1:1], take};
		end
	end

	// ------------------------------------------------------------------
	// Datapath
	// ------------------------------------------------------------------
	side_t              side_q [1:NSTG];
	side_t              side_d [1:NSTG];

	logic signed [33:0] dx_s1, dy_s1;
	logic signed [31:0] cx_s2, cy_s2;
	logic [63:0]        sqx_s3, sqy_s3;
	logic signed [63:0] r4_s7, k1r2_s7, p1r2_s7;
	logic signed [63:0] rad_s8, rad_s9, rad_s10, rad_s11, rad_s12, rad_s13, rad_s14;
	logic signed [63:0] p1r2_s8, p1r2_s9, p1r2_s10;
	logic signed [63:0] r6_s10, k2r4_s10, p2r4_s10;
	logic signed [63:0] tang_s11;
	logic [63:0]        tang_mag_s12, rad_mag_s15;
	logic               tang_neg_s12, rad_neg_s15;
	logic signed [63:0] k3r6_s13;
	logic signed [63:0] scx_s18, scy_s18;
	logic signed [63:0] ux_s19, uy_s19, ux_s20, uy_s20;
	logic signed [31:0] ux_s21, uy_s21;

	// product unit outputs
	logic [127:0] pr_r4, pr_k1, pr_p1, pr_r6, pr_k2, pr_p2, pr_k3;
	logic [127:0] pr_sx, pr_sy, pr_cx, pr_cy;
	logic         ng_r4, ng_k1, ng_p1, ng_r6, ng_k2, ng_p2, ng_k3;
	logic         ng_sx, ng_sy, ng_cx, ng_cy;

	// combinational stage results
	sat32_t      c_cx, c_cy, c_ox, c_oy;
	logic [64:0] c_sq;
	logic        c_r2_clamp;
	sat64_t      c_r4, c_k1, c_p1, c_rad8;
	sat64_t      c_r6, c_k2, c_p2, c_rad11, c_tang;
	sat64_t      c_k3, c_rad14, c_shx, c_shy, c_scx, c_scy;
	sat64_t      c_ux19, c_uy19, c_ux20, c_uy20;

	bcu_mul u_r4 (.clk, .en(adv), .a(side_q[4].r2), .b(side_q[4].r2), .neg(1'b0),
		.prod(pr_r4), .prod_neg(ng_r4));
	bcu_mul u_k1 (.clk, .en(adv), .a(coef_mag_q[COEF_K1]), .b(side_q[4].r2),
		.neg(coef_neg_q[COEF_K1]), .prod(pr_k1), .prod_neg(ng_k1));
	bcu_mul u_p1 (.clk, .en(adv), .a(coef_mag_q[COEF_P1]), .b(side_q[4].r2),
		.neg(coef_neg_q[COEF_P1]), .prod(pr_p1), .prod_neg(ng_p1));

	bcu_mul u_r6 (.clk, .en(adv), .a(64'(r4_s7)), .b(side_q[7].r2), .neg(1'b0),
		.prod(pr_r6), .prod_neg(ng_r6));
	bcu_mul u_k2 (.clk, .en(adv), .a(coef_mag_q[COEF_K2]), .b(64'(r4_s7)),
		.neg(coef_neg_q[COEF_K2]), .prod(pr_k2), .prod_neg(ng_k2));
	bcu_mul u_p2 (.clk, .en(adv), .a(coef_mag_q[COEF_P2]), .b(64'(r4_s7)),
		.neg(coef_neg_q[COEF_P2]), .prod(pr_p2), .prod_neg(ng_p2));

	bcu_mul u_k3 (.clk, .en(adv), .a(coef_mag_q[COEF_K3]), .b(64'(r6_s10)),
		.neg(coef_neg_q[COEF_K3]), .prod(pr_k3), .prod_neg(ng_k3));

	bcu_mul u_sx (.clk, .en(adv), .a(tang_mag_s12), .b({32'd0, sin_mag_q}),
		.neg(tang_neg_s12 ^ sin_neg_q), .prod(pr_sx), .prod_neg(ng_sx));
	bcu_mul u_sy (.clk, .en(adv), .a(tang_mag_s12), .b({32'd0, cos_mag_q}),
		.neg(tang_neg_s12 ^ cos_neg_q), .prod(pr_sy), .prod_neg(ng_sy));

	bcu_mul u_cx (.clk, .en(adv), .a({32'd0, side_q[15].cxm}), .b(rad_mag_s15),
		.neg(side_q[15].cxn ^ rad_neg_s15), .prod(pr_cx), .prod_neg(ng_cx));
	bcu_mul u_cy (.clk, .en(adv), .a({32'd0, side_q[15].cym}), .b(rad_mag_s15),
		.neg(side_q[15].cyn ^ rad_neg_s15), .prod(pr_cy), .prod_neg(ng_cy));

	always_comb begin
		c_cx       = sat32(64'(dx_s1));
		c_cy       = sat32(64'(dy_s1));
		c_sq       = {1'b0, sqx_s3} + {1'b0, sqy_s3};
		c_r2_clamp = c_sq[63];
		c_r4       = sat_shift(pr_r4, ng_r4, 32);
		c_k1       = sat_shift(pr_k1, ng_k1, 32);
		c_p1       = sat_shift(pr_p1, ng_p1, 56);
		c_rad8     = sadd64(Q56_ONE, k1r2_s7);
		c_r6       = sat_shift(pr_r6, ng_r6, 32);
		c_k2       = sat_shift(pr_k2, ng_k2, 32);
		c_p2       = sat_shift(pr_p2, ng_p2, 56);
		c_rad11    = sadd64(rad_s10, k2r4_s10);
		c_tang     = sadd64(p1r2_s10, p2r4_s10);
		c_k3       = sat_shift(pr_k3, ng_k3, 32);
		c_rad14    = sadd64(rad_s13, k3r6_s13);
		c_shx      = sat_shift(pr_sx, ng_sx, 46);
		c_shy      = sat_shift(pr_sy, ng_sy, 46);
		c_scx      = sat_shift(pr_cx, ng_cx, 56);
		c_scy      = sat_shift(pr_cy, ng_cy, 56);
		c_ux19     = ssub64(scx_s18, side_q[18].shx);
		c_uy19     = sadd64(scy_s18, side_q[18].shy);
		c_ux20     = sadd64(ux_s19, 64'(side_q[19].ox));
		c_uy20     = sadd64(uy_s19, 64'(side_q[19].oy));
		c_ox       = sat32(ux_s20);
		c_oy       = sat32(uy_s20);
	end

	// side band: pass down, fold in clamps and late fields where they appear
	always_comb begin
		side_d[1]    = '0;
		side_d[1].ox = camera_offset_x;
		side_d[1].oy = camera_offset_y;
		for (int k = 2; k <= NSTG; k++) begin
			side_d[k] = side_q[k-1];
		end
		side_d[2].clamp  = side_q[1].clamp | c_cx.clamp | c_cy.clamp;
		side_d[3].cxm    = cx_s2[31] ? 32'(-cx_s2) : 32'(cx_s2);
		side_d[3].cym    = cy_s2[31] ? 32'(-cy_s2) : 32'(cy_s2);
		side_d[3].cxn    = cx_s2[31];
		side_d[3].cyn    = cy_s2[31];
		side_d[4].r2     = c_r2_clamp ? 64'(S64_MAX) : c_sq[63:0];
		side_d[4].clamp  = side_q[3].clamp | c_r2_clamp;
		side_d[7].clamp  = side_q[6].clamp | c_r4.clamp | c_k1.clamp | c_p1.clamp;
		side_d[8].clamp  = side_q[7].clamp | c_rad8.clamp;
		side_d[10].clamp = side_q[9].clamp | c_r6.clamp | c_k2.clamp | c_p2.clamp;
		side_d[11].clamp = side_q[10].clamp | c_rad11.clamp | c_tang.clamp;
		side_d[13].clamp = side_q[12].clamp | c_k3.clamp;
		side_d[14].clamp = side_q[13].clamp | c_rad14.clamp;
		side_d[15].shx   = c_shx.val;
		side_d[15].shy   = c_shy.val;
		side_d[15].clamp = side_q[14].clamp | c_shx.clamp | c_shy.clamp;
		side_d[18].clamp = side_q[17].clamp | c_scx.clamp | c_scy.clamp;
		side_d[19].clamp = side_q[18].clamp | c_ux19.clamp | c_uy19.clamp;
		side_d[20].clamp = side_q[19].clamp | c_ux20.clamp | c_uy20.clamp;
		side_d[21].clamp = side_q[20].clamp | c_ox.clamp | c_oy.clamp;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 1; k <= NSTG; k++) begin
				side_q[k] <= side_d[k];
			end
			// centre on principal point plus camera offset
			dx_s1 <= 34'(pixel_x) - 34'(prx_q) - 34'(camera_offset_x);
			dy_s1 <= 34'(pixel_y) - 34'(pry_q) - 34'(camera_offset_y);
			cx_s2 <= c_cx.val;
			cy_s2 <= c_cy.val;
			sqx_s3 <= 64'(cx_s2 * cx_s2);
			sqy_s3 <= 64'(cy_s2 * cy_s2);
			// r4, k1 r2, p1 r2
			r4_s7   <= c_r4.val;
			k1r2_s7 <= c_k1.val;
			p1r2_s7 <= c_p1.val;
			rad_s8  <= c_rad8.val;
			p1r2_s8 <= p1r2_s7;
			rad_s9  <= rad_s8;
			p1r2_s9 <= p1r2_s8;
			// r6, k2 r4, p2 r4
			rad_s10  <= rad_s9;
			p1r2_s10 <= p1r2_s9;
			r6_s10   <= c_r6.val;
			k2r4_s10 <= c_k2.val;
			p2r4_s10 <= c_p2.val;
			rad_s11  <= c_rad11.val;
			tang_s11 <= c_tang.val;
			rad_s12      <= rad_s11;
			tang_mag_s12 <= mag64(tang_s11);
			tang_neg_s12 <= tang_s11[63];
			rad_s13  <= rad_s12;
			k3r6_s13 <= c_k3.val;
			rad_s14  <= c_rad14.val;
			rad_mag_s15 <= mag64(rad_s14);
			rad_neg_s15 <= rad_s14[63];
			scx_s18 <= c_scx.val;
			scy_s18 <= c_scy.val;
			ux_s19  <= c_ux19.val;
			uy_s19  <= c_uy19.val;
			ux_s20  <= c_ux20.val;
			uy_s20  <= c_uy20.val;
			ux_s21  <= c_ox.val;
			uy_s21  <= c_oy.val;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic signed [31:0] res_x_q, res_y_q;
	logic               res_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || !result_stall) begin
			res_valid_q <= vld_q[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid_q || !result_stall) begin
			res_x_q   <= ux_s21;
			res_y_q   <= uy_s21;
			res_sat_q <= side_q[NSTG].clamp;
		end
	end

	assign result_valid  = res_valid_q;
	assign undistorted_x = res_x_q;
	assign undistorted_y = res_y_q;
	assign saturated     = res_sat_q;

`ifndef ASSERT_OFF
	// an angle write must hold off new words until sine/cosine settle
	a_angle_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		angle_wr |=> point_stall)
		else $error("word accepted right after angle write");

	// full last stage behind a stalled output must freeze the input
	a_full_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NSTG] && res_valid_q && result_stall) |-> point_stall)
		else $error("input open while pipeline frozen");

	// frozen pipeline keeps its valid bits
	a_vld_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (vld_q == $past(vld_q)))
		else $error("valid bits moved while frozen");

	// CORDIC finishes by writing magnitudes before going idle
	a_cor_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(cor_state_q == COR_FIN) |=> (cor_state_q == COR_MAG))
		else $error("CORDIC sequence broken");
`endif

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for brown_conrady_undistort_top: random and corner
// points under changing lens settings, with a built-in fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;
	import bcu_pkg::*;

	localparam int WDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_PER_PHASE = 244;

	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
	} point_t;

	typedef struct {
		logic signed [31:0] ux;
		logic signed [31:0] uy;
		logic               sat;
	} undist_t;

	logic clk, arst_n;
	logic point_valid, point_stall;
	logic signed [31:0] pixel_x, pixel_y, camera_offset_x, camera_offset_y;
	logic result_valid, result_stall;
	logic signed [31:0] undistorted_x, undistorted_y;
	logic saturated;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [63:0] pwdata, prdata;

	brown_conrady_undistort_top dut (.*);

	// shadow copy of the lens settings and the CORDIC outputs
	longint m_prx, m_pry, m_k1, m_k2, m_k3, m_p1, m_p2;
	longint m_sin, m_cos;
	bit     clamp_hit;

	point_t  point_q[$];
	undist_t undist_q[$];

	int src_pct, snk_pct;
	int hold_req, hold_seen, hold_left;
	int err_cnt = 0;
	int n_in = 0;
	int n_out = 0;
	int n_sat = 0;
	int wdog = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// ---- saturating fixed-point helpers ----
	function automatic logic [63:0] magn(input longint a);
		return a < 0 ? 64'(-a) : 64'(a);
	endfunction

	// exact product, truncated toward zero by sh, clamped to 64 bits
	function automatic longint fx_mul(input longint a, input longint b, input int sh);
		logic [127:0] p;
		logic [63:0]  q;
		bit           over, neg;
		p    = 128'(magn(a)) * 128'(magn(b));
		p    = p >> sh;
		over = |p[127:64];
		q    = p[63:0];
		neg  = (a < 0) != (b < 0);
		if (!neg) begin
			if (over || q[63]) begin
				clamp_hit = 1;
				return S64_MAX;
			end
			return longint'(q);
		end
		if (over || q > 64'h8000_0000_0000_0000) begin
			clamp_hit = 1;
			return S64_MIN;
		end
		return longint'(-q);
	endfunction

	function automatic longint fx_add(input longint a, input longint b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63]) begin
			clamp_hit = 1;
			return s[64] ? S64_MIN : S64_MAX;
		end
		return s[63:0];
	endfunction

	function automatic longint fx_sub(input longint a, input longint b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s[64] != s[63]) begin
			clamp_hit = 1;
			return s[64] ? S64_MIN : S64_MAX;
		end
		return s[63:0];
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) begin
			clamp_hit = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clamp_hit = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// sine/cosine of the decentering angle, folded into +-pi/2 first
	function automatic void rotate_angle(input logic signed [31:0] ang);
		longint z, x, y, t;
		bit     flip;
		z    = longint'(ang) * 2;
		x    = COR_GAIN;
		y    = 0;
		flip = 0;
		if (z > Q30_HALF_PI) begin
			z -= Q30_PI;
			flip = 1;
		end else if (z < -Q30_HALF_PI) begin
			z += Q30_PI;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_STEPS && i < ATAN_N; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				x = t;
				z -= longint'(ATAN_TBL[i]);
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				x = t;
				z += longint'(ATAN_TBL[i]);
			end
		end
		m_cos = flip ? -x : x;
		m_sin = flip ? -y : y;
	endfunction

	function automatic undist_t undistort(input point_t p);
		longint  cx, cy, r2, r4, r6, rad, tang, ux, uy;
		logic [63:0] sq;
		undist_t r;
		clamp_hit = 0;
		cx = clip32(longint'(p.px) - m_prx - longint'(p.ox));
		cy = clip32(longint'(p.py) - m_pry - longint'(p.oy));
		sq = 64'(cx * cx) + 64'(cy * cy);
		if (sq[63]) begin
			clamp_hit = 1;
			r2 = S64_MAX;
		end else
			r2 = longint'(sq);
		r4   = fx_mul(r2, r2, 32);
		r6   = fx_mul(r4, r2, 32);
		rad  = fx_add(Q56_ONE, fx_mul(m_k1, r2, 32));
		rad  = fx_add(rad, fx_mul(m_k2, r4, 32));
		rad  = fx_add(rad, fx_mul(m_k3, r6, 32));
		tang = fx_add(fx_mul(m_p1, r2, 56), fx_mul(m_p2, r4, 56));
		ux   = fx_sub(fx_mul(cx, rad, 56), fx_mul(tang, m_sin, 46));
		uy   = fx_add(fx_mul(cy, rad, 56), fx_mul(tang, m_cos, 46));
		ux   = clip32(fx_add(ux, longint'(p.ox)));
		uy   = clip32(fx_add(uy, longint'(p.oy)));
		r.ux  = ux[31:0];
		r.uy  = uy[31:0];
		r.sat = clamp_hit;
		return r;
	endfunction

	// ---- point driver: pops a word on each handshake, random sender gaps ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_valid     <= 0;
			pixel_x         <= 0;
			pixel_y         <= 0;
			camera_offset_x <= 0;
			camera_offset_y <= 0;
		end else begin
			if (point_valid && !point_stall) begin
				undist_q = {undist_q, undistort(point_q.pop_front())};
				n_in++;
			end
			// a stalled word must stay put
			if (!(point_valid && point_stall)) begin
				if (point_q.size() > 0 && $urandom_range(99) >= src_pct) begin
					point_valid     <= 1;
					pixel_x         <= point_q[0].px;
					pixel_y         <= point_q[0].py;
					camera_offset_x <= point_q[0].ox;
					camera_offset_y <= point_q[0].oy;
				end else
					point_valid <= 0;
			end
		end
	end

	// ---- result sink: random stalls plus an occasional long hold-off ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 0;
			hold_seen    <= 0;
			hold_left    <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen    <= hold_req;
			hold_left    <= HOLD_CYCLES;
			result_stall <= 1;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			result_stall <= 1;
		end else
			result_stall <= ($urandom_range(99) < snk_pct);
	end

	// ---- monitor: compare each accepted result with the oldest prediction ----
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (undist_q.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h sat=%b", $time,
					undistorted_x, undistorted_y, saturated);
				err_cnt++;
			end else begin
				undist_t e;
				e = undist_q.pop_front();
				n_out++;
				if (saturated) n_sat++;
				if (undistorted_x !== e.ux) begin
					$display("%0t: undistorted_x exp %h got %h", $time, e.ux, undistorted_x);
					err_cnt++;
				end
				if (undistorted_y !== e.uy) begin
					$display("%0t: undistorted_y exp %h got %h", $time, e.uy, undistorted_y);
					err_cnt++;
				end
				if (saturated !== e.sat) begin
					$display("%0t: saturated exp %b got %b", $time, e.sat, saturated);
					err_cnt++;
				end
			end
		end
	end

	// ---- watchdog: cycles with no point or result handshake and no APB select ----
	always @(posedge clk) begin
		if ((point_valid && !point_stall) || (result_valid && !result_stall) || psel)
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_LIMIT) begin
			$display("watchdog expired, %0d results still pending", undist_q.size());
			$display("tb NOT OK");
			$finish;
		end
	end

	// ---- stimulus helpers ----
	task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
		logic [63:0] rd_exp;
		@(posedge clk);
		psel    <= 1;
		penable <= 0;
		pwrite  <= 1;
		paddr   <= ADDR_W'(idx) << 3;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel    <= 0;
		penable <= 0;
		pwrite  <= 0;
		case (idx)
			REG_PRINCIPAL_X, REG_PRINCIPAL_Y, REG_DECENTER_ANGLE:
				rd_exp = 64'($signed(val[31:0]));
			default: rd_exp = val;
		endcase
		// read back through the same address
		@(posedge clk);
		if (!pready || prdata !== rd_exp) begin
			$display("%0t: read back reg %0d exp %h got %h", $time, idx, rd_exp, prdata);
			err_cnt++;
		end
		case (idx)
			REG_PRINCIPAL_X:    m_prx = longint'($signed(val[31:0]));
			REG_PRINCIPAL_Y:    m_pry = longint'($signed(val[31:0]));
			REG_RADIAL_K1:      m_k1  = val;
			REG_RADIAL_K2:      m_k2  = val;
			REG_RADIAL_K3:      m_k3  = val;
			REG_DECENTER_P1:    m_p1  = val;
			REG_DECENTER_P2:    m_p2  = val;
			REG_DECENTER_ANGLE: begin
				rotate_angle(val[31:0]);
				// let the CORDIC finish before anything else
				repeat (CORDIC_STEPS + 16) @(posedge clk);
			end
			default: ;
		endcase
	endtask

	task automatic set_lens(input longint prx, pry, k1, k2, k3, p1, p2,
			input logic signed [31:0] ang);
		reg_write(REG_PRINCIPAL_X, 64'(prx));
		reg_write(REG_PRINCIPAL_Y, 64'(pry));
		reg_write(REG_RADIAL_K1, k1);
		reg_write(REG_RADIAL_K2, k2);
		reg_write(REG_RADIAL_K3, k3);
		reg_write(REG_DECENTER_P1, p1);
		reg_write(REG_DECENTER_P2, p2);
		reg_write(REG_DECENTER_ANGLE, 64'(longint'(ang)));
	endtask

	function automatic longint rnd64(input int maxsh);
		longint v;
		v = {$urandom, $urandom};
		return v >>> $urandom_range(maxsh);
	endfunction

	// coordinate: mostly moderate magnitudes, sometimes full range
	function automatic logic signed [31:0] rnd_coord();
		logic signed [31:0] v;
		v = $urandom;
		return v >>> $urandom_range(31);
	endfunction

	function automatic void add_point(input logic signed [31:0] px, py, ox, oy);
		point_t p;
		p.px = px;
		p.py = py;
		p.ox = ox;
		p.oy = oy;
		point_q = {point_q, p};
	endfunction

	task automatic drain();
		while (point_q.size() > 0 || point_valid || undist_q.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic run_random(input int n);
		for (int i = 0; i < n; i++)
			add_point(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
	endtask

	initial begin
		arst_n   = 0;
		psel     = 0;
		penable  = 0;
		pwrite   = 0;
		paddr    = 0;
		pwdata   = 0;
		src_pct  = 0;
		snk_pct  = 0;
		hold_req = 0;
		m_prx = 0; m_pry = 0; m_k1 = 0; m_k2 = 0; m_k3 = 0; m_p1 = 0; m_p2 = 0;
		// after reset sine and cosine are exact, not a CORDIC result
		m_sin = 0;
		m_cos = Q30_ONE;
		repeat (4) @(posedge clk);
		arst_n = 1;
		@(posedge clk);

		// directed corners under reset settings: identity transform
		add_point(0, 0, 0, 0);
		add_point(S32_MAX, S32_MAX, 0, 0);
		add_point(S32_MIN, S32_MIN, 0, 0);
		add_point(S32_MAX, S32_MIN, S32_MIN, S32_MAX);
		add_point(S32_MIN, S32_MAX, S32_MAX, S32_MIN);
		add_point(32'sh0001_0000, -32'sh0001_0000, 0, 0);
		add_point(-1, -1, -1, -1);
		add_point(32'sh0010_0000, 32'sh0020_0000, 32'sh0001_0000, -32'sh0003_0000);
		drain();

		// realistic lens, small angle; corners again
		set_lens(32'sh0140_0000, 32'sh00F0_0000, 64'sd7200000000, -64'sd400, 64'sd1,
			64'sd300000000, -64'sd20, 32'sh0800_0000);
		add_point(0, 0, 0, 0);
		add_point(32'sh0140_0000, 32'sh00F0_0000, 0, 0);
		add_point(S32_MAX, S32_MAX, S32_MIN, S32_MIN);
		add_point(S32_MIN, S32_MIN, S32_MAX, S32_MAX);
		add_point(32'sh0180_0000, 32'sh0100_0000, 32'sh0002_0000, 32'sh0001_8000);
		add_point(32'sh0000_8000, 32'sh0000_4000, 0, 0);
		run_random(RAND_PER_PHASE);
		drain();

		// extreme coefficients, angle at +pi
		set_lens(S32_MAX, S32_MIN, S64_MAX, S64_MIN, S64_MAX, S64_MIN, S64_MAX,
			32'sd1686629713);
		add_point(S32_MAX, S32_MIN, 0, 0);
		add_point(0, 0, 0, 0);
		add_point(S32_MIN, S32_MAX, S32_MAX, S32_MIN);
		src_pct = 50;
		run_random(RAND_PER_PHASE);
		drain();

		// angle at -pi, other extremes reversed
		set_lens(S32_MIN, S32_MAX, S64_MIN, S64_MAX, S64_MIN, S64_MAX, S64_MIN,
			-32'sd1686629713);
		add_point(S32_MAX, S32_MIN, 0, 0);
		add_point(32'sh0001_0000, 32'sh0001_0000, 0, 0);
		src_pct = 0;
		snk_pct = 50;
		run_random(RAND_PER_PHASE);
		drain();

		// angles beyond +-pi fold too; full 32-bit limits
		set_lens(0, 0, rnd64(40), rnd64(63), rnd64(63), rnd64(40), rnd64(63), S32_MAX);
		src_pct = 10;
		snk_pct = 10;
		run_random(RAND_PER_PHASE);
		drain();
		reg_write(REG_DECENTER_ANGLE, 64'(longint'(S32_MIN)));
		run_random(RAND_PER_PHASE / 2);
		drain();

		// long output hold-off while points keep coming: pipeline backs up
		set_lens(rnd_coord(), rnd_coord(), rnd64(63), rnd64(63), rnd64(63), rnd64(63),
			rnd64(63), 32'($signed($urandom_range(0, 2 * 1686629713)) - 1686629713));
		src_pct = 0;
		snk_pct = 0;
		run_random(RAND_PER_PHASE);
		hold_req++;
		drain();

		// random settings, all idling modes in turn
		for (int ph = 0; ph < 4; ph++) begin
			set_lens(rnd_coord(), rnd_coord(), rnd64(63), rnd64(63), rnd64(63),
				rnd64(63), rnd64(63), $urandom);
			src_pct = (ph == 1) ? 50 : (ph == 2 ? 10 : 0);
			snk_pct = (ph == 3) ? 50 : (ph == 2 ? 10 : 0);
			run_random(RAND_PER_PHASE / 2);
			drain();
		end

		$display("covered %0d points, %0d results (%0d clamped), 11 lens settings,",
			n_in, n_out, n_sat);
		$display("sender gaps, receiver stalls and a long output hold-off");
		if (err_cnt == 0 && undist_q.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
